>>> hdl/psc_pkg.sv
// Shared types, codes and helpers of the PSU serial command unit.
package psc_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    CMD_SERIAL = 2'd0,
    CMD_ADC    = 2'd1,
    CMD_TEMP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Setpoint argument awaited after a set command
  typedef enum logic [1:0] {
    ARG_NONE = 2'd0,
    ARG_VOLT = 2'd1,
    ARG_AMP  = 2'd2
  } arg_t;

  // Command letters
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SET_V  = 8'h56; // 'V'
  localparam logic [7:0] CH_SET_A  = 8'h41; // 'A'
  localparam logic [7:0] CH_READ_V = 8'h76; // 'v'
  localparam logic [7:0] CH_READ_A = 8'h61; // 'a'
  localparam logic [7:0] CH_READ_T = 8'h74; // 't'
  localparam logic [7:0] CH_STATUS = 8'h73; // 's'
  localparam logic [7:0] CH_OUT_ON = 8'h4F; // 'O'
  localparam logic [7:0] CH_OUT_OFF = 8'h6F; // 'o'

  // Reply bytes
  localparam logic [7:0] REPLY_ACK = 8'd13;
  localparam logic [7:0] REPLY_ERR = 8'd63; // '?'

  localparam logic [7:0] LIMIT_RESET = 8'd250;
  localparam logic [7:0] READING_MAX = 8'd255;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  // One input item
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  rx_byte;
    logic [9:0]  adc_value;
    logic [7:0]  temperature;
  } item_t;

  // Round a 10-bit conversion to 8 bits, saturating at full scale
  function automatic logic [7:0] adc_round(input logic [9:0] v);
    logic [7:0] hi;
    hi = v[9:2];
    if (hi != READING_MAX && v[1]) begin
      hi = hi + 8'd1;
    end
    return hi;
  endfunction

endpackage

>>> hdl/psc_in_reg.sv
// Input register stage of the PSU serial command unit.
module psc_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  psc_pkg::item_t               in_item,
  input  logic                         advance,
  output logic                         item_valid,
  output psc_pkg::item_t               item
);
  import psc_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Take a new item when empty or when the held one moves on
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/psc_engine.sv
// Command decode, supply state and result register of the PSU serial command unit.
module psc_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wen,
  input  logic [7:0]                            cfg_wdata,
  input  logic                                  item_valid,
  input  psc_pkg::item_t                        item,
  output logic                                  advance,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_tx_valid,
  output logic [psc_pkg::OUT_TDATA_W-1:0]       out_data
);
  import psc_pkg::*;

  logic       [7:0] limit_r;
  arg_t             pending_r, pending_nxt;
  logic       [7:0] volt_meas_r, volt_meas_nxt;
  logic       [7:0] amp_meas_r, amp_meas_nxt;
  logic       [7:0] temp_meas_r, temp_meas_nxt;
  logic             adc_on_volt_r, adc_on_volt_nxt;
  logic       [7:0] volt_set_r, volt_set_nxt;
  logic       [7:0] amp_set_r, amp_set_nxt;
  logic             out_on_r, out_on_nxt;
  logic             remote_r, remote_nxt;
  logic             tx_nxt;
  logic       [7:0] tb_nxt;
  logic       [7:0] adc_rounded;
  logic             out_valid_r;
  logic             tx_valid_r;
  logic [OUT_TDATA_W-1:0] data_r;

  // Move the held item into the result register when it is free
  assign advance      = item_valid && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_tx_valid = tx_valid_r;
  assign out_data     = data_r;

  assign adc_rounded = adc_round(item.adc_value);

  // Decode the item and work out the next state and reply
  always_comb begin
    pending_nxt     = pending_r;
    volt_meas_nxt   = volt_meas_r;
    amp_meas_nxt    = amp_meas_r;
    temp_meas_nxt   = temp_meas_r;
    adc_on_volt_nxt = adc_on_volt_r;
    volt_set_nxt    = volt_set_r;
    amp_set_nxt     = amp_set_r;
    out_on_nxt      = out_on_r;
    remote_nxt      = remote_r;
    tx_nxt          = 1'b0;
    tb_nxt          = 8'd0;
    unique case (item.cmd)
      CMD_SERIAL: begin
        pending_nxt = ARG_NONE;
        if (pending_r == ARG_VOLT || pending_r == ARG_AMP) begin
          // Argument byte: accept it up to the limit
          tx_nxt = 1'b1;
          if (item.rx_byte <= limit_r) begin
            if (pending_r == ARG_VOLT) begin
              volt_set_nxt = item.rx_byte;
            end else begin
              amp_set_nxt = item.rx_byte;
            end
            remote_nxt = 1'b1;
            tb_nxt     = REPLY_ACK;
          end else begin
            tb_nxt = REPLY_ERR;
          end
        end else begin
          unique case (item.rx_byte)
            CH_ESC: ;
            CH_SET_V: pending_nxt = ARG_VOLT;
            CH_SET_A: pending_nxt = ARG_AMP;
            CH_READ_V: begin
              tx_nxt = 1'b1;
              tb_nxt = volt_meas_r;
            end
            CH_READ_A: begin
              tx_nxt = 1'b1;
              tb_nxt = amp_meas_r;
            end
            CH_READ_T: begin
              tx_nxt = 1'b1;
              tb_nxt = temp_meas_r;
            end
            CH_STATUS: begin
              tx_nxt = 1'b1;
              tb_nxt = {7'd0, out_on_r};
            end
            CH_OUT_ON: begin
              out_on_nxt = 1'b1;
              remote_nxt = 1'b1;
              tx_nxt     = 1'b1;
              tb_nxt     = REPLY_ACK;
            end
            CH_OUT_OFF: begin
              out_on_nxt = 1'b0;
              remote_nxt = 1'b1;
              tx_nxt     = 1'b1;
              tb_nxt     = REPLY_ACK;
            end
            default: begin
              tx_nxt = 1'b1;
              tb_nxt = REPLY_ERR;
            end
          endcase
        end
      end
      CMD_ADC: begin
        // Alternate between current and voltage channel
        if (adc_on_volt_r) begin
          volt_meas_nxt = adc_rounded;
        end else begin
          amp_meas_nxt = adc_rounded;
        end
        adc_on_volt_nxt = !adc_on_volt_r;
      end
      CMD_TEMP: temp_meas_nxt = item.temperature;
      default: ;
    endcase
  end

  // Hold configuration and supply state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      pending_r     <= ARG_NONE;
      volt_meas_r   <= 8'd0;
      amp_meas_r    <= 8'd0;
      temp_meas_r   <= 8'd0;
      adc_on_volt_r <= 1'b0;
      volt_set_r    <= 8'd0;
      amp_set_r     <= 8'd0;
      out_on_r      <= 1'b0;
      remote_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        limit_r <= cfg_wdata;
      end
      if (advance) begin
        pending_r     <= pending_nxt;
        volt_meas_r   <= volt_meas_nxt;
        amp_meas_r    <= amp_meas_nxt;
        temp_meas_r   <= temp_meas_nxt;
        adc_on_volt_r <= adc_on_volt_nxt;
        volt_set_r    <= volt_set_nxt;
        amp_set_r     <= amp_set_nxt;
        out_on_r      <= out_on_nxt;
        remote_r      <= remote_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      tx_valid_r <= tx_nxt;
      data_r     <= {6'd0, amp_meas_nxt, volt_meas_nxt, remote_nxt, out_on_nxt,
                     amp_set_nxt, volt_set_nxt, tb_nxt};
    end
  end

endmodule

>>> hdl/psu_serial_command_unit_core.sv
// Top level of the PSU serial command unit.
// An accepted item is held in the input register, then its result in the result register;
// the state update and decode sit between the two.
// Throughput: one item per cycle while out_tready is high; the result register frees as it is taken.
// Reset (rst_n low, synchronous): both stages empty, setpoints, readings and flags
// cleared, no argument pending, setpoint limit 250.
module psu_serial_command_unit_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [7:0]                         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] rx_byte, [17:8] adc_value, [25:18] temperature, [31:26] zero
  input  logic [psc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] tx_byte, [15:8] voltage_setpoint, [23:16] current_setpoint,
  // [24] output_enabled, [25] remote_active, [33:26] voltage_reading,
  // [41:34] current_reading, [47:42] zero
  output logic [psc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] tx_valid
  output logic                               out_tuser
);
  import psc_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  // Unpack the input item
  assign in_item.cmd         = cmd_t'(in_tuser);
  assign in_item.rx_byte     = in_tdata[7:0];
  assign in_item.adc_value   = in_tdata[17:8];
  assign in_item.temperature = in_tdata[25:18];

  psc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  psc_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item         (item),
    .advance      (advance),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_tx_valid (out_tuser),
    .out_data     (out_tdata)
  );

endmodule

>>> tb/tb_psu_serial_command_unit_core.sv
// Self-checking testbench for the PSU serial command unit: directed rows, then random traffic.
module tb_psu_serial_command_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  // Supply status as seen on the result channel
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] volt_sp;
    logic [7:0] amp_sp;
    logic       out_en;
    logic       remote;
    logic [7:0] volt_rd;
    logic [7:0] amp_rd;
  } status_t;

  // Directed row: item fields, then an optional reply read off by hand
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic [9:0] adc_value;
    logic [7:0] temperature;
    logic       has_reply;
    logic       reply_valid;
    logic [7:0] reply_byte;
  } row_t;

  localparam int DIR_N = 28;
  localparam int PHASE_ITEMS = 125;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [7:0]             cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Shadow copy of the supply state and the setpoint limit
  arg_t       awaited = ARG_NONE;
  logic [7:0] setpoint_cap = LIMIT_RESET;
  logic [7:0] volt_read = '0;
  logic [7:0] amp_read = '0;
  logic [7:0] temp_read = '0;
  logic       adc_to_volt = 1'b0;
  logic [7:0] volt_sp = '0;
  logic [7:0] amp_sp = '0;
  logic       output_on = 1'b0;
  logic       remote_flag = 1'b0;

  status_t status_q[$];
  int      errs = 0;
  int      phase_items = 0;
  bit      no_idle = 1'b0;

  logic [7:0] letters [10] = '{CH_READ_V, CH_READ_A, CH_READ_T, CH_STATUS, CH_SET_V,
                               CH_SET_A, CH_OUT_ON, CH_OUT_OFF, CH_ESC, 8'h00};
  logic [7:0] cap_list [6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, LIMIT_RESET};

  row_t dir_rows [DIR_N] = '{
    '{CMD_SERIAL, CH_STATUS,  10'd0,     8'd0,   1'b1, 1'b1, 8'd0},
    '{CMD_ADC,    8'd0,       10'h3FF,   8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_ADC,    8'd0,       10'h000,   8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_ADC,    8'd0,       10'h006,   8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_ADC,    8'd0,       10'h3FA,   8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, CH_READ_A,  10'd0,     8'd0,   1'b1, 1'b1, 8'd2},
    '{CMD_SERIAL, CH_READ_V,  10'd0,     8'd0,   1'b1, 1'b1, READING_MAX},
    '{CMD_TEMP,   8'd0,       10'd0,     8'hA5,  1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, CH_READ_T,  10'd0,     8'd0,   1'b1, 1'b1, 8'hA5},
    '{CMD_SERIAL, CH_SET_V,   10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, 8'd250,     10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK},
    '{CMD_SERIAL, CH_SET_A,   10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, 8'd251,     10'd0,     8'd0,   1'b1, 1'b1, REPLY_ERR},
    '{CMD_SERIAL, CH_SET_V,   10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_ADC,    8'd0,       10'h155,   8'd0,   1'b0, 1'b0, 8'd0},
    '{CMD_SERIAL, CH_OUT_ON,  10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK},
    '{CMD_SERIAL, CH_OUT_ON,  10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK},
    '{CMD_SERIAL, CH_STATUS,  10'd0,     8'd0,   1'b1, 1'b1, 8'd1},
    '{CMD_SERIAL, CH_OUT_OFF, 10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK},
    '{CMD_SERIAL, CH_STATUS,  10'd0,     8'd0,   1'b1, 1'b1, 8'd0},
    '{CMD_SERIAL, CH_ESC,     10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, 8'h00,      10'd0,     8'd0,   1'b1, 1'b1, REPLY_ERR},
    '{CMD_SERIAL, 8'hFF,      10'd0,     8'd0,   1'b1, 1'b1, REPLY_ERR},
    '{CMD_UNUSED, CH_OUT_ON,  10'h3FF,   8'hFF,  1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, CH_SET_A,   10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, CH_ESC,     10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK},
    '{CMD_SERIAL, CH_SET_A,   10'd0,     8'd0,   1'b1, 1'b0, 8'd0},
    '{CMD_SERIAL, 8'd0,       10'd0,     8'd0,   1'b1, 1'b1, REPLY_ACK}
  };

  psu_serial_command_unit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Advance the shadow state by one item and return the status it leaves behind
  task automatic step_supply(input item_t it, output status_t st);
    logic [8:0] rounded;
    st = '0;
    case (it.cmd)
      CMD_SERIAL: begin
        if (awaited != ARG_NONE) begin
          // Any byte is the argument while a setpoint is awaited
          st.tx_valid = 1'b1;
          if (it.rx_byte <= setpoint_cap) begin
            if (awaited == ARG_VOLT) volt_sp = it.rx_byte;
            else amp_sp = it.rx_byte;
            remote_flag = 1'b1;
            st.tx_byte = REPLY_ACK;
          end else begin
            st.tx_byte = REPLY_ERR;
          end
          awaited = ARG_NONE;
        end else begin
          case (it.rx_byte)
            CH_ESC: ;
            CH_SET_V: awaited = ARG_VOLT;
            CH_SET_A: awaited = ARG_AMP;
            CH_READ_V: begin st.tx_valid = 1'b1; st.tx_byte = volt_read; end
            CH_READ_A: begin st.tx_valid = 1'b1; st.tx_byte = amp_read; end
            CH_READ_T: begin st.tx_valid = 1'b1; st.tx_byte = temp_read; end
            CH_STATUS: begin st.tx_valid = 1'b1; st.tx_byte = {7'd0, output_on}; end
            CH_OUT_ON, CH_OUT_OFF: begin
              output_on = (it.rx_byte == CH_OUT_ON);
              remote_flag = 1'b1;
              st.tx_valid = 1'b1;
              st.tx_byte = REPLY_ACK;
            end
            default: begin st.tx_valid = 1'b1; st.tx_byte = REPLY_ERR; end
          endcase
        end
      end
      CMD_ADC: begin
        // Round half up from 10 to 8 bits; a carry out means full scale
        rounded = {1'b0, it.adc_value[9:2]} + {8'd0, it.adc_value[1]};
        if (adc_to_volt) volt_read = rounded[8] ? READING_MAX : rounded[7:0];
        else amp_read = rounded[8] ? READING_MAX : rounded[7:0];
        adc_to_volt = ~adc_to_volt;
      end
      CMD_TEMP: temp_read = it.temperature;
      default: ;
    endcase
    st.volt_sp = volt_sp;
    st.amp_sp  = amp_sp;
    st.out_en  = output_on;
    st.remote  = remote_flag;
    st.volt_rd = volt_read;
    st.amp_rd  = amp_read;
  endtask

  // Random item of the given kind; unused fields carry random bits
  function automatic item_t junk_item(input cmd_t c);
    item_t it;
    it.cmd         = c;
    it.rx_byte     = 8'($urandom);
    it.adc_value   = 10'($urandom);
    it.temperature = 8'($urandom);
    return it;
  endfunction

  // Offer one item, idling now and then, and queue its status once taken
  task automatic send_item(input item_t it, input logic has_reply = 1'b0,
                           input logic reply_valid = 1'b0, input logic [7:0] reply_byte = '0);
    status_t st;
    while (!no_idle && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.temperature, it.adc_value, it.rx_byte};
    in_tuser  <= it.cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_supply(it, st);
    if (has_reply) begin
      st.tx_valid = reply_valid;
      st.tx_byte  = reply_byte;
    end
    status_q.push_back(st);
    if (it.cmd != CMD_UNUSED) phase_items++;
    no_idle = (phase_items >= 30 && phase_items < 80);
  endtask

  // Send one random command or a short command sequence
  task automatic send_random_burst();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 28) begin
      // Set command with its argument, sometimes a measurement in between
      it = junk_item(CMD_SERIAL);
      it.rx_byte = $urandom_range(1) ? CH_SET_V : CH_SET_A;
      send_item(it);
      if ($urandom_range(99) < 20) send_item(junk_item($urandom_range(1) ? CMD_ADC : CMD_TEMP));
      it = junk_item(CMD_SERIAL);
      case ($urandom_range(4))
        0: it.rx_byte = setpoint_cap;
        1: it.rx_byte = setpoint_cap + 8'd1;
        2: it.rx_byte = 8'($urandom_range(setpoint_cap));
        3: it.rx_byte = letters[$urandom_range(9)];
        default: ;
      endcase
      send_item(it);
    end else if (pick < 58) begin
      it = junk_item(CMD_SERIAL);
      it.rx_byte = letters[$urandom_range(3)];
      send_item(it);
    end else if (pick < 66) begin
      it = junk_item(CMD_SERIAL);
      it.rx_byte = $urandom_range(1) ? CH_OUT_ON : CH_OUT_OFF;
      send_item(it);
    end else if (pick < 80) begin
      it = junk_item(CMD_ADC);
      if ($urandom_range(3) == 0) it.adc_value = 10'($urandom_range(1023, 1016));
      send_item(it);
    end else if (pick < 86) begin
      send_item(junk_item(CMD_TEMP));
    end else if (pick < 89) begin
      it = junk_item(CMD_SERIAL);
      it.rx_byte = CH_ESC;
      send_item(it);
    end else if (pick < 96) begin
      send_item(junk_item(CMD_SERIAL));
    end else begin
      send_item(junk_item(CMD_UNUSED));
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // Take results with random stalls and compare against the oldest status
  always @(posedge clk) begin : take_status
    status_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result item with none expected, tdata %h", out_tdata);
          errs++;
        end else begin
          want = status_q.pop_front();
          check_field("tx_valid", want.tx_valid, out_tuser);
          check_field("tx_byte", want.tx_byte, out_tdata[7:0]);
          check_field("voltage_setpoint", want.volt_sp, out_tdata[15:8]);
          check_field("current_setpoint", want.amp_sp, out_tdata[23:16]);
          check_field("output_enabled", want.out_en, out_tdata[24]);
          check_field("remote_active", want.remote, out_tdata[25]);
          check_field("voltage_reading", want.volt_rd, out_tdata[33:26]);
          check_field("current_reading", want.amp_rd, out_tdata[41:34]);
        end
      end
      out_tready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  // Main sequence: reset, directed rows, then random phases over several limits
  initial begin : drive
    logic [7:0] cap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_item('{dir_rows[i].cmd, dir_rows[i].rx_byte, dir_rows[i].adc_value,
                  dir_rows[i].temperature},
                dir_rows[i].has_reply, dir_rows[i].reply_valid, dir_rows[i].reply_byte);
    end

    for (int p = 0; p < 6; p++) begin
      // Drain, let the pipeline settle, then write the new limit
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (status_q.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cap = cap_list[p];
      if (p == 4) cap = 8'($urandom_range(255));
      cfg_wen   <= 1'b1;
      cfg_wdata <= cap;
      @(posedge clk);
      cfg_wen <= 1'b0;
      setpoint_cap = cap;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_burst();
    end

    // Hold off until every expected result is in, then report the verdict
    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
